// File: sv/rbpt_pkg.sv
// Shared types and codes for the reorder buffer with pending tags.
// No dependencies; imported by every module of the block.
package rbpt_pkg;

  // fixed field widths of the request and response channels
  localparam int REQ_W  = 3;
  localparam int OP_W   = 4;
  localparam int STAT_W = 2;

  // request kinds carried on in_tuser
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 3'd0,
    REQ_WB     = 3'd1,
    REQ_COMMIT = 3'd2,
    REQ_FLUSH  = 3'd3,
    REQ_LOOKUP = 3'd4
  } req_code_t;

  // response status carried on out_tuser
  typedef enum logic [STAT_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } stat_code_t;

  // operation codes that matter to the buffer
  localparam logic [OP_W-1:0] OP_STORE = 4'd1;
  localparam logic [OP_W-1:0] OP_BEQ   = 4'd2;
  localparam logic [OP_W-1:0] OP_CALL  = 4'd3;
  localparam logic [OP_W-1:0] OP_RET   = 4'd4;

endpackage

// File: sv/reorder_buffer_with_pending_tags.sv
// Reorder buffer with pending-register tags: top level.
// A request is held in the input register, then its response in the response
// register; a stalled response holds the next request in the input register.
// Throughput: one request per cycle, limited only by out_tready.
// Reset (rst_n low, synchronous) empties the buffer and clears all pending
// marks; no clearing pass, requests are taken right after reset.
// Depends on rbpt_pkg, rbpt_in_stage, rbpt_core and rbpt_out_stage.
module reorder_buffer_with_pending_tags #(
  parameter int ROB_DEPTH  = 8,
  parameter int NUM_REGS   = 128,
  parameter int DATA_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // req_type
  input  logic [rbpt_pkg::REQ_W-1:0] in_tuser,
  // op_type, reg_index, rob_tag, wb_value, wb_taken, zero pad
  input  logic [((rbpt_pkg::OP_W + $clog2(NUM_REGS) +
                  ((ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1) +
                  DATA_WIDTH + 1 + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // status
  output logic [rbpt_pkg::STAT_W-1:0] out_tuser,
  // tag, reg_pending, commit_type, commit_dest, commit_value,
  // commit_writes_reg, redirect, occupancy, zero pad
  output logic [((((ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1) + 1 +
                  rbpt_pkg::OP_W + $clog2(NUM_REGS) + DATA_WIDTH + 2 +
                  $clog2(ROB_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata
);
  import rbpt_pkg::*;

  localparam int IN_TDATA_W  = $bits(in_tdata);
  localparam int OUT_TDATA_W = $bits(out_tdata);

  logic                   req_valid;
  logic                   req_take;
  logic [REQ_W-1:0]       req_kind;
  logic [IN_TDATA_W-1:0]  req_data;
  logic                   res_free;
  logic [STAT_W-1:0]      res_tuser;
  logic [OUT_TDATA_W-1:0] res_tdata;

  rbpt_in_stage #(
    .TDATA_W(IN_TDATA_W)
  ) u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .req_take (req_take),
    .req_valid(req_valid),
    .req_kind (req_kind),
    .req_data (req_data)
  );

  rbpt_core #(
    .ROB_DEPTH  (ROB_DEPTH),
    .NUM_REGS   (NUM_REGS),
    .DATA_WIDTH (DATA_WIDTH),
    .IN_TDATA_W (IN_TDATA_W),
    .OUT_TDATA_W(OUT_TDATA_W)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_kind (req_kind),
    .req_data (req_data),
    .res_free (res_free),
    .req_take (req_take),
    .res_tuser(res_tuser),
    .res_tdata(res_tdata)
  );

  rbpt_out_stage #(
    .TDATA_W(OUT_TDATA_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (req_take),
    .res_tuser (res_tuser),
    .res_tdata (res_tdata),
    .res_free  (res_free),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

endmodule

// File: sv/rbpt_in_stage.sv
// Request input register with its stream handshake.
// Depends on rbpt_pkg for the request kind width.
module rbpt_in_stage #(
  parameter int TDATA_W = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [rbpt_pkg::REQ_W-1:0] in_tuser,
  input  logic [TDATA_W-1:0]        in_tdata,
  input  logic                      req_take,
  output logic                      req_valid,
  output logic [rbpt_pkg::REQ_W-1:0] req_kind,
  output logic [TDATA_W-1:0]        req_data
);
  import rbpt_pkg::*;

  logic               valid_r, valid_nxt;
  logic [REQ_W-1:0]   kind_r;
  logic [TDATA_W-1:0] data_r;
  logic               load;

  // register is free when empty or drained this cycle
  assign in_tready = !valid_r || req_take;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (req_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload holds without reset
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= in_tuser;
      data_r <= in_tdata;
    end
  end

  assign req_valid = valid_r;
  assign req_kind  = kind_r;
  assign req_data  = data_r;

endmodule

// File: sv/rbpt_core.sv
// Buffer state and the single-pass request logic: entries, pointers and
// per-entry ownership flags that stand in for the pending-tag table.
// Depends on rbpt_pkg for request, status and operation codes.
module rbpt_core #(
  parameter int ROB_DEPTH   = 8,
  parameter int NUM_REGS    = 128,
  parameter int DATA_WIDTH  = 16,
  parameter int IN_TDATA_W  = 32,
  parameter int OUT_TDATA_W = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  logic [rbpt_pkg::REQ_W-1:0]  req_kind,
  input  logic [IN_TDATA_W-1:0]      req_data,
  input  logic                       res_free,
  output logic                       req_take,
  output logic [rbpt_pkg::STAT_W-1:0] res_tuser,
  output logic [OUT_TDATA_W-1:0]     res_tdata
);
  import rbpt_pkg::*;

  localparam int TAG_W = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
  localparam int CNT_W = $clog2(ROB_DEPTH + 1);
  localparam int REG_W = $clog2(NUM_REGS);

  // request field offsets in tdata
  localparam int F_REG = OP_W;
  localparam int F_TAG = F_REG + REG_W;
  localparam int F_VAL = F_TAG + TAG_W;
  localparam int F_TKN = F_VAL + DATA_WIDTH;

  localparam logic [TAG_W-1:0] LAST_TAG  = TAG_W'(ROB_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ROB_DEPTH);

  // entry payload, no reset
  logic [OP_W-1:0]       type_r   [ROB_DEPTH];
  logic [REG_W-1:0]      dest_r   [ROB_DEPTH];
  logic                  hasdst_r [ROB_DEPTH];
  logic [DATA_WIDTH-1:0] value_r  [ROB_DEPTH];
  logic                  taken_r  [ROB_DEPTH];

  // control state
  logic [ROB_DEPTH-1:0] ready_r, ready_nxt;
  logic [ROB_DEPTH-1:0] owner_r, owner_nxt;
  logic [TAG_W-1:0]     head_r, head_nxt;
  logic [TAG_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  // unpacked request fields
  logic [OP_W-1:0]       f_op;
  logic [REG_W-1:0]      f_reg;
  logic [TAG_W-1:0]      f_tag;
  logic [DATA_WIDTH-1:0] f_val;
  logic                  f_taken;

  logic                  fire;
  logic                  full;
  logic                  op_hasdst;
  logic                  reg_ok;
  logic                  tag_ok;
  logic                  claim;
  logic                  alloc_we;
  logic                  wb_we;
  logic                  can_commit;
  logic [OP_W-1:0]       h_type;
  logic                  h_redir;
  logic [ROB_DEPTH-1:0]  match;
  logic [TAG_W-1:0]      match_tag;

  // response fields
  logic [STAT_W-1:0]     r_status;
  logic [TAG_W-1:0]      r_tag;
  logic                  r_pend;
  logic [OP_W-1:0]       r_type;
  logic [REG_W-1:0]      r_dest;
  logic [DATA_WIDTH-1:0] r_val;
  logic                  r_wr;
  logic                  r_redir;

  assign f_op    = req_data[F_REG-1:0];
  assign f_reg   = req_data[F_TAG-1:F_REG];
  assign f_tag   = req_data[F_VAL-1:F_TAG];
  assign f_val   = req_data[F_TKN-1:F_VAL];
  assign f_taken = req_data[F_TKN];

  assign req_take = req_valid && res_free;
  assign fire     = req_take;

  // request qualifiers
  assign full      = (count_r == FULL_CNT);
  assign op_hasdst = !(f_op == OP_STORE || f_op == OP_BEQ ||
                       f_op == OP_CALL  || f_op == OP_RET);
  assign reg_ok    = ({1'b0, f_reg} < (REG_W + 1)'(NUM_REGS));
  assign tag_ok    = ({1'b0, f_tag} < (TAG_W + 1)'(ROB_DEPTH));
  assign claim     = op_hasdst && reg_ok;
  assign alloc_we  = fire && (req_kind == REQ_ALLOC) && !full;
  assign wb_we     = fire && (req_kind == REQ_WB) && tag_ok;

  // head entry view
  assign h_type     = type_r[head_r];
  assign can_commit = (count_r != '0) && ready_r[head_r];
  assign h_redir    = (h_type == OP_CALL) || (h_type == OP_RET) ||
                      ((h_type == OP_BEQ) && taken_r[head_r]);

  // owner search: at most one entry owns a register
  always_comb begin
    match_tag = '0;
    for (int i = 0; i < ROB_DEPTH; i++) begin
      match[i] = owner_r[i] && (dest_r[i] == f_reg);
      if (match[i]) begin
        match_tag = match_tag | TAG_W'(i);
      end
    end
  end

  // next state and response
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ready_nxt = ready_r;
    owner_nxt = owner_r;
    r_status  = STAT_DONE;
    r_tag     = '0;
    r_pend    = 1'b0;
    r_type    = '0;
    r_dest    = '0;
    r_val     = '0;
    r_wr      = 1'b0;
    r_redir   = 1'b0;
    if (fire) begin
      case (req_kind)
        REQ_ALLOC: begin
          if (full) begin
            r_status = STAT_FULL;
          end else begin
            // new writer takes over the register from any older one
            for (int i = 0; i < ROB_DEPTH; i++) begin
              if (claim && dest_r[i] == f_reg) begin
                owner_nxt[i] = 1'b0;
              end
            end
            owner_nxt[tail_r] = claim;
            ready_nxt[tail_r] = 1'b0;
            tail_nxt  = (tail_r == LAST_TAG) ? '0 : tail_r + 1'b1;
            count_nxt = count_r + 1'b1;
            r_tag     = tail_r;
          end
        end
        REQ_WB: begin
          if (tag_ok) begin
            ready_nxt[f_tag] = 1'b1;
          end
        end
        REQ_COMMIT: begin
          if (!can_commit) begin
            r_status = STAT_NONE;
          end else begin
            r_type  = h_type;
            r_dest  = dest_r[head_r];
            r_val   = value_r[head_r];
            r_wr    = hasdst_r[head_r];
            r_redir = h_redir;
            if (h_redir) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
              ready_nxt = '0;
              owner_nxt = '0;
            end else begin
              ready_nxt[head_r] = 1'b0;
              owner_nxt[head_r] = 1'b0;
              head_nxt  = (head_r == LAST_TAG) ? '0 : head_r + 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end
        end
        REQ_FLUSH: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
          ready_nxt = '0;
          owner_nxt = '0;
        end
        REQ_LOOKUP: begin
          r_pend = |match;
          r_tag  = match_tag;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      ready_r <= '0;
      owner_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ready_r <= ready_nxt;
      owner_r <= owner_nxt;
    end
  end

  // entry payload writes
  always_ff @(posedge clk) begin
    if (alloc_we) begin
      type_r[tail_r]   <= f_op;
      dest_r[tail_r]   <= f_reg;
      hasdst_r[tail_r] <= op_hasdst;
    end
    if (wb_we) begin
      value_r[f_tag] <= f_val;
      taken_r[f_tag] <= f_taken;
    end
  end

  // response packing, lowest field first
  assign res_tuser = r_status;
  assign res_tdata = OUT_TDATA_W'({count_nxt, r_redir, r_wr, r_val, r_dest,
                                   r_type, r_pend, r_tag});

endmodule

// File: sv/rbpt_out_stage.sv
// Response register with its stream handshake.
// Depends on rbpt_pkg for the status width.
module rbpt_out_stage #(
  parameter int TDATA_W = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_load,
  input  logic [rbpt_pkg::STAT_W-1:0]  res_tuser,
  input  logic [TDATA_W-1:0]          res_tdata,
  output logic                        res_free,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [rbpt_pkg::STAT_W-1:0]  out_tuser,
  output logic [TDATA_W-1:0]          out_tdata
);
  import rbpt_pkg::*;

  logic               valid_r, valid_nxt;
  logic [STAT_W-1:0]  user_r;
  logic [TDATA_W-1:0] data_r;

  // free when empty or being taken this cycle
  assign res_free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      user_r <= res_tuser;
      data_r <= res_tdata;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = user_r;
  assign out_tdata  = data_r;

endmodule

// File: sv/rbpt_checker.sv
// Port-level checks for the reorder buffer, bound to the top level.
// Depends on rbpt_pkg and reorder_buffer_with_pending_tags.
module rbpt_checker #(
  parameter int ROB_DEPTH  = 8,
  parameter int NUM_REGS   = 128,
  parameter int DATA_WIDTH = 16
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [rbpt_pkg::STAT_W-1:0] out_tuser,
  input logic [((((ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1) + 1 +
                 rbpt_pkg::OP_W + $clog2(NUM_REGS) + DATA_WIDTH + 2 +
                 $clog2(ROB_DEPTH + 1) + 7) / 8) * 8 - 1:0] out_tdata
);
  import rbpt_pkg::*;

  localparam int TAG_W  = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
  localparam int CNT_W  = $clog2(ROB_DEPTH + 1);
  localparam int REG_W  = $clog2(NUM_REGS);
  localparam int O_RDR  = TAG_W + 1 + OP_W + REG_W + DATA_WIDTH + 1;
  localparam int O_OCC  = O_RDR + 1;

  logic [CNT_W-1:0] occ;
  logic             redir;

  assign occ     = out_tdata[O_OCC + CNT_W - 1:O_OCC];
  assign redir   = out_tdata[O_RDR];

  // a stalled response holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser))
    else $error("stalled response changed");

  // occupancy never exceeds the depth
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ <= CNT_W'(ROB_DEPTH))
    else $error("occupancy beyond depth");

  // a refused allocate reports a full buffer
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_FULL |-> occ == CNT_W'(ROB_DEPTH))
    else $error("full status with room left");

  // a redirecting commit leaves the buffer empty
  a_redir_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && redir |-> occ == '0 && out_tuser == STAT_DONE)
    else $error("redirect did not empty the buffer");

  // right after a reset cycle nothing comes out and requests are taken
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("response or stall right after reset");

endmodule

bind reorder_buffer_with_pending_tags rbpt_checker #(
  .ROB_DEPTH (ROB_DEPTH),
  .NUM_REGS  (NUM_REGS),
  .DATA_WIDTH(DATA_WIDTH)
) u_rbpt_checker (.*);

// File: tb/tb_reorder_buffer_with_pending_tags.sv
// Self-checking testbench for reorder_buffer_with_pending_tags: a directed table
// followed by random requests; each response is checked against its fixed table row or a local predictor.
// Depends on rbpt_pkg and the reorder_buffer_with_pending_tags RTL.
module tb_reorder_buffer_with_pending_tags;
  import rbpt_pkg::*;

  localparam int ROB_D  = 8;
  localparam int NREGS  = 128;
  localparam int DW     = 16;
  localparam int IN_W   = 32;
  localparam int OUT_W  = 40;
  localparam int N_RAND = 900;

  // operation codes not named in the package
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd0;
  localparam logic [OP_W-1:0] OP_ADD      = 4'd5;
  localparam logic [OP_W-1:0] OP_SUB      = 4'd6;
  localparam logic [OP_W-1:0] OP_NAND     = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL      = 4'd8;
  localparam logic [OP_W-1:0] OP_MAX_CODE = 4'd15;

  // request codes with no function
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [OP_W-1:0]  op;
    logic [6:0]       rix;
    logic [2:0]       wtag;
    logic [DW-1:0]    value;
    logic             taken;
  } rob_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] stat;
    logic [2:0]        tag;
    logic              pend;
    logic [OP_W-1:0]   ctype;
    logic [6:0]        cdest;
    logic [DW-1:0]     cval;
    logic              cwr;
    logic              redir;
    logic [3:0]        occ;
  } rob_resp_t;

  typedef struct {
    rob_req_t  q;
    bit        fixed;
    rob_resp_t resp;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [REQ_W-1:0] in_tuser;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [STAT_W-1:0] out_tuser;
  logic [OUT_W-1:0] out_tdata;

  reorder_buffer_with_pending_tags #(
    .ROB_DEPTH (ROB_D),
    .NUM_REGS  (NREGS),
    .DATA_WIDTH(DW)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  // predicted buffer contents and pending table
  logic [OP_W-1:0] m_type  [ROB_D];
  logic [6:0]      m_dest  [ROB_D];
  logic            m_hasd  [ROB_D];
  logic [DW-1:0]   m_val   [ROB_D];
  logic            m_taken [ROB_D];
  logic            m_ready [ROB_D];
  logic [2:0]      m_head;
  logic [2:0]      m_tail;
  logic [3:0]      m_used;
  logic            m_pv [NREGS];
  logic [2:0]      m_pt [NREGS];

  rob_resp_t due_resps[$];
  dir_row_t  dir_rows[$];
  bit        row_fixed;
  rob_resp_t row_resp;
  int        bad_count;
  bit        long_hold;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic void clear_rob();
    m_head = '0;
    m_tail = '0;
    m_used = '0;
    for (int i = 0; i < ROB_D; i++) m_ready[i] = 1'b0;
    for (int i = 0; i < NREGS; i++) begin
      m_pv[i] = 1'b0;
      m_pt[i] = '0;
    end
  endfunction

  // apply one request to the predicted state and return its response
  function automatic rob_resp_t rob_apply(rob_req_t q);
    rob_resp_t r;
    logic [2:0] t;
    logic       hd;
    logic       redir;
    r = '0;
    case (q.kind)
      REQ_ALLOC: begin
        if (m_used >= ROB_D) begin
          r.stat = STAT_FULL;
        end else begin
          t = m_tail;
          hd = !(q.op == OP_STORE || q.op == OP_BEQ || q.op == OP_CALL || q.op == OP_RET);
          m_type[t] = q.op;
          m_dest[t] = q.rix;
          m_hasd[t] = hd;
          m_ready[t] = 1'b0;
          if (hd) begin
            m_pv[q.rix] = 1'b1;
            m_pt[q.rix] = t;
          end
          m_tail = t + 3'd1;
          m_used = m_used + 4'd1;
          r.tag = t;
        end
      end
      REQ_WB: begin
        m_val[q.wtag] = q.value;
        m_taken[q.wtag] = q.taken;
        m_ready[q.wtag] = 1'b1;
      end
      REQ_COMMIT: begin
        t = m_head;
        if (m_used == 0 || !m_ready[t]) begin
          r.stat = STAT_NONE;
        end else begin
          redir = m_type[t] == OP_CALL || m_type[t] == OP_RET ||
                  (m_type[t] == OP_BEQ && m_taken[t]);
          r.ctype = m_type[t];
          r.cdest = m_dest[t];
          r.cval = m_val[t];
          r.cwr = m_hasd[t];
          r.redir = redir;
          // only the newest writer's tag clears the pending mark
          if (m_hasd[t] && m_pv[m_dest[t]] && m_pt[m_dest[t]] == t) begin
            m_pv[m_dest[t]] = 1'b0;
            m_pt[m_dest[t]] = '0;
          end
          if (redir) begin
            clear_rob();
          end else begin
            m_ready[t] = 1'b0;
            m_head = t + 3'd1;
            m_used = m_used - 4'd1;
          end
        end
      end
      REQ_FLUSH: clear_rob();
      REQ_LOOKUP: begin
        if (m_pv[q.rix]) begin
          r.tag = m_pt[q.rix];
          r.pend = 1'b1;
        end
      end
      default: ;
    endcase
    r.occ = m_used;
    return r;
  endfunction

  function automatic logic [6:0] pick_reg();
    // mostly a few registers so writers collide
    if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, NREGS - 1));
    return 7'($urandom_range(0, 7));
  endfunction

  // random request shaped by the current predicted state
  function automatic rob_req_t pick_req();
    rob_req_t q;
    int pick;
    int k;
    q.op = OP_W'($urandom_range(0, OP_MAX_CODE));
    q.rix = 7'($urandom_range(0, NREGS - 1));
    q.wtag = 3'($urandom_range(0, ROB_D - 1));
    q.value = DW'($urandom_range(0, (1 << DW) - 1));
    q.taken = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      q.kind = REQ_ALLOC;
      q.rix = pick_reg();
      k = $urandom_range(0, 19);
      if (k == 0) q.op = OP_CALL;
      else if (k == 1) q.op = OP_RET;
      else if (k <= 3) q.op = OP_BEQ;
      else if (k <= 5) q.op = OP_STORE;
      else if (k == 6) q.op = OP_W'($urandom_range(OP_MUL + 1, OP_MAX_CODE));
      else begin
        case ($urandom_range(0, 4))
          0: q.op = OP_LOAD;
          1: q.op = OP_ADD;
          2: q.op = OP_SUB;
          3: q.op = OP_NAND;
          default: q.op = OP_MUL;
        endcase
      end
    end else if (pick < 55) begin
      q.kind = REQ_WB;
      if (m_used != 0 && $urandom_range(0, 9) != 0) begin
        if ($urandom_range(0, 1) == 1) q.wtag = m_head;
        else q.wtag = m_head + 3'($urandom_range(0, m_used - 1));
      end
      q.taken = ($urandom_range(0, 3) == 0);
    end else if (pick < 80) begin
      q.kind = REQ_COMMIT;
    end else if (pick < 93) begin
      q.kind = REQ_LOOKUP;
      q.rix = pick_reg();
    end else if (pick < 96) begin
      q.kind = REQ_FLUSH;
    end else begin
      q.kind = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    end
    return q;
  endfunction

  // append one row to the directed table
  function automatic void add_row(logic [REQ_W-1:0] kind, logic [OP_W-1:0] op,
                                  logic [6:0] rix, logic [2:0] wtag,
                                  logic [DW-1:0] value, logic taken, bit fixed,
                                  logic [STAT_W-1:0] stat, logic [2:0] tag,
                                  logic pend, logic [3:0] occ);
    dir_row_t d;
    d.q = '{kind, op, rix, wtag, value, taken};
    d.fixed = fixed;
    d.resp = '0;
    d.resp.stat = stat;
    d.resp.tag = tag;
    d.resp.pend = pend;
    d.resp.occ = occ;
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // drop valid for an idle gap set by n, called right after an accepting edge
  task automatic idle(int n);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // present one request at the current falling edge and wait for its accept
  task automatic offer(rob_req_t q);
    in_tvalid <= 1'b1;
    in_tuser <= q.kind;
    in_tdata <= {1'b0, q.taken, q.value, q.wtag, q.rix, q.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // response sink with random back-pressure and one long hold-off
  initial begin
    out_tready = 1'b0;
    while (!rst_n) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (80) @(negedge clk);
        long_hold = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // predict on each accepted request, check each accepted response
  always @(posedge clk) begin : mon
    rob_req_t  q;
    rob_resp_t pred;
    rob_resp_t got;
    rob_resp_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        q = '{in_tuser, in_tdata[3:0], in_tdata[10:4], in_tdata[13:11],
              in_tdata[29:14], in_tdata[30]};
        pred = rob_apply(q);
        due_resps.insert(due_resps.size(), row_fixed ? row_resp : pred);
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[2:0], out_tdata[3], out_tdata[7:4], out_tdata[14:8],
                out_tdata[30:15], out_tdata[31], out_tdata[32], out_tdata[36:33]};
        if (due_resps.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) $display("unexpected response: %p", got);
        end else begin
          want = due_resps.pop_front();
          if (got !== want) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("mismatch: expected stat=%0d tag=%0d pend=%0b type=%0d dest=%0d",
                       want.stat, want.tag, want.pend, want.ctype, want.cdest);
              $display("  val=%h wr=%0b redir=%0b occ=%0d", want.cval, want.cwr,
                       want.redir, want.occ);
              $display("  got stat=%0d tag=%0d pend=%0b type=%0d dest=%0d",
                       got.stat, got.tag, got.pend, got.ctype, got.cdest);
              $display("  val=%h wr=%0b redir=%0b occ=%0d", got.cval, got.cwr,
                       got.redir, got.occ);
            end
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    row_fixed = 1'b0;
    row_resp = '0;
    bad_count = 0;
    long_hold = 1'b0;
    for (int i = 0; i < ROB_D; i++) begin
      m_type[i] = '0;
      m_dest[i] = '0;
      m_hasd[i] = 1'b0;
      m_val[i] = '0;
      m_taken[i] = 1'b0;
    end
    clear_rob();

    // directed table: fill, overflow, newer writer, flush, redirecting commit, spare code
    add_row(REQ_LOOKUP, OP_LOAD, 7'd0, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_COMMIT, OP_LOAD, 7'd0, 3'd0, '0, 1'b0, 1,
            STAT_NONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_ALLOC, OP_LOAD, 7'd127, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd0, 1'b0, 4'd1);
    add_row(REQ_ALLOC, OP_MUL, 7'd0, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd1, 1'b0, 4'd2);
    add_row(REQ_ALLOC, OP_MAX_CODE, 7'd5, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd2, 1'b0, 4'd3);
    add_row(REQ_ALLOC, OP_STORE, 7'd9, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd3, 1'b0, 4'd4);
    add_row(REQ_ALLOC, OP_BEQ, 7'd10, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd4, 1'b0, 4'd5);
    add_row(REQ_ALLOC, OP_ADD, 7'd127, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd5, 1'b0, 4'd6);
    add_row(REQ_ALLOC, OP_SUB, 7'd1, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd6, 1'b0, 4'd7);
    add_row(REQ_ALLOC, OP_NAND, 7'd2, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd7, 1'b0, 4'd8);
    add_row(REQ_ALLOC, OP_CALL, 7'd3, 3'd0, '0, 1'b0, 1,
            STAT_FULL, 3'd0, 1'b0, 4'd8);
    add_row(REQ_LOOKUP, OP_LOAD, 7'd127, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd5, 1'b1, 4'd8);
    add_row(REQ_COMMIT, OP_LOAD, 7'd0, 3'd0, '0, 1'b0, 1,
            STAT_NONE, 3'd0, 1'b0, 4'd8);
    add_row(REQ_WB, OP_LOAD, 7'd0, 3'd0, 16'hFFFF, 1'b1, 0,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_COMMIT, OP_LOAD, 7'd0, 3'd0, '0, 1'b0, 0,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_LOOKUP, OP_LOAD, 7'd127, 3'd0, '0, 1'b0, 0,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_WB, OP_LOAD, 7'd0, 3'd1, 16'h0000, 1'b0, 0,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_COMMIT, OP_LOAD, 7'd0, 3'd0, '0, 1'b0, 0,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_FLUSH, OP_LOAD, 7'd0, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_LOOKUP, OP_LOAD, 7'd127, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_ALLOC, OP_CALL, 7'd3, 3'd0, '0, 1'b0, 1,
            STAT_DONE, 3'd0, 1'b0, 4'd1);
    add_row(REQ_WB, OP_LOAD, 7'd0, 3'd0, 16'h8001, 1'b0, 0,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_COMMIT, OP_LOAD, 7'd0, 3'd0, '0, 1'b0, 0,
            STAT_DONE, 3'd0, 1'b0, 4'd0);
    add_row(REQ_SPARE_HI, OP_MAX_CODE, 7'd127, 3'd7, 16'hFFFF, 1'b1, 1,
            STAT_DONE, 3'd0, 1'b0, 4'd0);

    // reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (dir_rows[i]) begin
      if ($urandom_range(0, 2) == 0) idle(gap_len());
      @(negedge clk);
      row_fixed = dir_rows[i].fixed;
      row_resp = dir_rows[i].resp;
      offer(dir_rows[i].q);
    end

    // random part, with bursts that never idle
    for (int n = 0; n < N_RAND; n++) begin
      if (n == 200) long_hold = 1'b1;
      if (n == 500) begin
        // let every outstanding response drain before going on
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (due_resps.size() != 0) @(posedge clk);
      end
      if ((n / 64) % 3 != 1 && $urandom_range(0, 2) == 0) idle(gap_len());
      @(negedge clk);
      row_fixed = 1'b0;
      offer(pick_req());
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (due_resps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rbpt_pkg.sv
sv/rbpt_in_stage.sv
sv/rbpt_core.sv
sv/rbpt_out_stage.sv
sv/reorder_buffer_with_pending_tags.sv
sv/rbpt_checker.sv
tb/tb_reorder_buffer_with_pending_tags.sv
